### rtl/key_gesture_classifier_assert.svh
// assertion macros for the key gesture classifier
`ifndef KEY_GESTURE_CLASSIFIER_ASSERT_SVH
`define KEY_GESTURE_CLASSIFIER_ASSERT_SVH

// implication checked on every clock edge outside reset
`define KGC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequence checked in the cycle after the antecedent
`define KGC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/kgc_pkg.sv
// ----------------------------------------------------------------------------
// kgc_pkg
// shared types and constants of the key gesture classifier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package kgc_pkg;
   localparam int NumKeys = 4;
   localparam int KeyWidth = 2;
   localparam int MaxResults = 4;

   localparam logic [1:0] MODE_IDLE     = 2'd0;
   localparam logic [1:0] MODE_DOWN     = 2'd1;
   localparam logic [1:0] MODE_SHORT    = 2'd2;
   localparam logic [1:0] MODE_POSTHOLD = 2'd3;

   localparam logic [1:0] GEST_SHORT  = 2'd0;
   localparam logic [1:0] GEST_DOUBLE = 2'd1;
   localparam logic [1:0] GEST_HOLD   = 2'd2;

   localparam logic       OP_EVENT = 1'b0;
   localparam logic       OP_TICK  = 1'b1;

   localparam logic [1:0] REG_DEBOUNCE = 2'd0;
   localparam logic [1:0] REG_SHORT    = 2'd1;
   localparam logic [1:0] REG_HOLD     = 2'd2;
   localparam logic [1:0] REG_DOUBLE   = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic                load;      // capture input word
      logic                check;     // ordering check and time update
      logic                sweep;     // evaluate one key of the sweep
      logic [KeyWidth-1:0] sweep_key;
      logic                handle;    // event handling on the event key
      logic                emit_pop;  // one result word taken
   } kgc_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic                is_tick;
      logic                accept_event; // event passed range and order checks
      logic [2:0]          result_count; // queued gestures
   } kgc_status_type;
endpackage
`default_nettype wire

### rtl/kgc_datapath.sv
// ----------------------------------------------------------------------------
// kgc_datapath
// per-key state, sweep evaluation, event handling and result queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module kgc_datapath
   import kgc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           csr_write,
   input  wire logic [1:0]     csr_index,
   input  wire logic [15:0]    csr_data,
   input  wire logic           in_opcode,
   input  wire logic [1:0]     in_key_index,
   input  wire logic           in_pressed,
   input  wire logic [31:0]    in_event_time,
   input  wire logic [31:0]    in_host_time,
   input  wire kgc_cmd_type    cmd,
   output      kgc_status_type status,
   output      logic           out_valid_res,
   output      logic [1:0]     out_gesture_key,
   output      logic [1:0]     out_gesture,
   output      logic [31:0]    out_gesture_time,
   output      logic [31:0]    out_dropped_count,
   output      logic           out_last
);
   logic [15:0] debounce_ff, short_ff, hold_ff, dwin_ff;

   logic        op_ff, down_ff;
   logic [1:0]  key_ff;
   logic [31:0] et_ff, ht_ff;

   logic [1:0]  mode_ff     [NumKeys];
   logic        seen_ff     [NumKeys];
   logic [31:0] latest_ff   [NumKeys];
   logic [31:0] prev_ff     [NumKeys];
   logic [31:0] anc_dev_ff  [NumKeys];
   logic [31:0] anc_host_ff [NumKeys];
   logic [31:0] fc_dev_ff   [NumKeys];
   logic [31:0] fc_host_ff  [NumKeys];
   logic        second_ff   [NumKeys];
   logic        rel_ff      [NumKeys];
   logic [31:0] now_ff;
   logic [31:0] drop_ff;
   logic        accept_ff;

   logic [1:0]  q_key_ff  [MaxResults];
   logic [1:0]  q_gest_ff [MaxResults];
   logic [31:0] q_time_ff [MaxResults];
   logic [2:0]  q_cnt_ff;
   logic [1:0]  q_rd_ff;

   // wrap-safe signed differences
   logic [31:0] sw_now, sw_anc, sw_el;
   logic        sw_hold_hit, sw_dwin_hit;
   logic [31:0] ev_order_d, ev_glob_d, ev_prev_d, ev_anc_d;
   logic        ev_in_range, ev_order_ok;
   logic        push;
   logic [1:0]  push_key, push_gest;
   logic [31:0] push_time;
   logic        drop;

   assign sw_now = op_ff ? ht_ff : now_ff;
   assign sw_anc = op_ff ? anc_host_ff[cmd.sweep_key] : anc_dev_ff[cmd.sweep_key];
   assign sw_el  = sw_now - sw_anc;
   assign sw_hold_hit = !sw_el[31] && (sw_el >= {16'd0, hold_ff});
   assign sw_dwin_hit = !sw_el[31] && (sw_el >= {16'd0, dwin_ff});

   assign ev_in_range = ({1'b0, key_ff} < 3'(NumKeys));
   assign ev_order_d  = et_ff - latest_ff[key_ff];
   assign ev_order_ok = !(seen_ff[key_ff] && ev_order_d[31]);
   assign ev_glob_d   = et_ff - now_ff;
   assign ev_prev_d   = et_ff - prev_ff[key_ff];
   assign ev_anc_d    = et_ff - anc_dev_ff[key_ff];

   always_comb begin
      push = 1'b0;
      push_key = cmd.sweep_key;
      push_gest = GEST_SHORT;
      push_time = anc_dev_ff[cmd.sweep_key];
      drop = 1'b0;
      if (cmd.check && (!ev_in_range || !ev_order_ok)) begin
         drop = 1'b1;
      end
      if (cmd.sweep) begin
         if (mode_ff[cmd.sweep_key] == MODE_DOWN && sw_hold_hit) begin
            push = 1'b1;
            push_gest = GEST_HOLD;
            push_time = anc_dev_ff[cmd.sweep_key] + {16'd0, hold_ff};
         end else if (mode_ff[cmd.sweep_key] == MODE_SHORT && sw_dwin_hit) begin
            push = 1'b1;
         end
      end
      if (cmd.handle) begin
         push_key = key_ff;
         push_gest = GEST_DOUBLE;
         push_time = et_ff;
         if (!down_ff) begin
            if (mode_ff[key_ff] != MODE_POSTHOLD && mode_ff[key_ff] != MODE_DOWN) begin
               drop = 1'b1;
            end else if (mode_ff[key_ff] == MODE_DOWN) begin
               if (!(ev_anc_d[31] || ev_anc_d < {16'd0, debounce_ff}) && second_ff[key_ff])
                  push = 1'b1;
            end
         end else begin
            if (!(rel_ff[key_ff] && (ev_prev_d[31] || ev_prev_d < {16'd0, debounce_ff}))
                && mode_ff[key_ff] == MODE_DOWN) begin
               drop = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= 16'd30;
         short_ff <= 16'd400;
         hold_ff <= 16'd800;
         dwin_ff <= 16'd300;
      end else if (csr_write) begin
         case (csr_index)
            REG_DEBOUNCE: debounce_ff <= csr_data;
            REG_SHORT:    short_ff <= csr_data;
            REG_HOLD:     hold_ff <= csr_data;
            REG_DOUBLE:   dwin_ff <= csr_data;
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= in_opcode;
         key_ff <= in_key_index;
         down_ff <= in_pressed;
         et_ff <= in_event_time;
         ht_ff <= in_host_time;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumKeys; i++) begin
            mode_ff[i] <= MODE_IDLE;
            seen_ff[i] <= 1'b0;
            latest_ff[i] <= '0;
            prev_ff[i] <= '0;
            anc_dev_ff[i] <= '0;
            anc_host_ff[i] <= '0;
            fc_dev_ff[i] <= '0;
            fc_host_ff[i] <= '0;
            second_ff[i] <= 1'b0;
            rel_ff[i] <= 1'b0;
         end
         now_ff <= '0;
         drop_ff <= '0;
         accept_ff <= 1'b0;
         q_cnt_ff <= '0;
         q_rd_ff <= '0;
      end else begin
         if (drop && drop_ff != 32'hFFFF_FFFF) drop_ff <= drop_ff + 32'd1;
         if (cmd.load) begin
            q_cnt_ff <= '0;
            q_rd_ff <= '0;
            accept_ff <= 1'b0;
         end
         if (cmd.check) begin
            accept_ff <= ev_in_range && ev_order_ok;
            if (ev_in_range && ev_order_ok) begin
               prev_ff[key_ff] <= latest_ff[key_ff];
               seen_ff[key_ff] <= 1'b1;
               latest_ff[key_ff] <= et_ff;
               if (!ev_glob_d[31] && ev_glob_d != 32'd0) now_ff <= et_ff;
            end
         end
         if (push && q_cnt_ff < 3'(MaxResults)) begin
            q_key_ff[q_cnt_ff[1:0]] <= push_key;
            q_gest_ff[q_cnt_ff[1:0]] <= push_gest;
            q_time_ff[q_cnt_ff[1:0]] <= push_time;
            q_cnt_ff <= q_cnt_ff + 3'd1;
         end
         if (cmd.emit_pop) q_rd_ff <= q_rd_ff + 2'd1;
         if (cmd.sweep) begin
            if (mode_ff[cmd.sweep_key] == MODE_DOWN && sw_hold_hit)
               mode_ff[cmd.sweep_key] <= MODE_POSTHOLD;
            else if (mode_ff[cmd.sweep_key] == MODE_SHORT && sw_dwin_hit)
               mode_ff[cmd.sweep_key] <= MODE_IDLE;
         end
         if (cmd.handle) begin
            if (down_ff) begin
               if (rel_ff[key_ff] && (ev_prev_d[31] || ev_prev_d < {16'd0, debounce_ff})) begin
                  // press inside debounce gap ignored
               end else if (mode_ff[key_ff] == MODE_SHORT) begin
                  fc_dev_ff[key_ff] <= anc_dev_ff[key_ff];
                  fc_host_ff[key_ff] <= anc_host_ff[key_ff];
                  mode_ff[key_ff] <= MODE_DOWN;
                  second_ff[key_ff] <= 1'b1;
                  anc_dev_ff[key_ff] <= et_ff;
                  anc_host_ff[key_ff] <= ht_ff;
                  rel_ff[key_ff] <= 1'b0;
               end else if (mode_ff[key_ff] != MODE_DOWN) begin
                  mode_ff[key_ff] <= MODE_DOWN;
                  second_ff[key_ff] <= 1'b0;
                  anc_dev_ff[key_ff] <= et_ff;
                  anc_host_ff[key_ff] <= ht_ff;
                  rel_ff[key_ff] <= 1'b0;
               end
            end else if (mode_ff[key_ff] == MODE_POSTHOLD) begin
               mode_ff[key_ff] <= MODE_IDLE;
               rel_ff[key_ff] <= 1'b1;
            end else if (mode_ff[key_ff] == MODE_DOWN) begin
               rel_ff[key_ff] <= 1'b1;
               if (ev_anc_d[31] || ev_anc_d < {16'd0, debounce_ff}) begin
                  if (second_ff[key_ff]) begin
                     mode_ff[key_ff] <= MODE_SHORT;
                     anc_dev_ff[key_ff] <= fc_dev_ff[key_ff];
                     anc_host_ff[key_ff] <= fc_host_ff[key_ff];
                  end else begin
                     mode_ff[key_ff] <= MODE_IDLE;
                  end
               end else if (second_ff[key_ff]) begin
                  mode_ff[key_ff] <= MODE_IDLE;
               end else if (ev_anc_d <= {16'd0, short_ff}) begin
                  mode_ff[key_ff] <= MODE_SHORT;
                  anc_dev_ff[key_ff] <= et_ff;
                  anc_host_ff[key_ff] <= ht_ff;
               end else begin
                  mode_ff[key_ff] <= MODE_IDLE;
               end
            end
         end
      end
   end

   assign status.is_tick = (op_ff == OP_TICK);
   assign status.accept_event = accept_ff;
   assign status.result_count = q_cnt_ff;

   always_comb begin
      if (q_cnt_ff == 3'd0) begin
         out_valid_res = 1'b0;
         out_gesture_key = '0;
         out_gesture = '0;
         out_gesture_time = '0;
         out_last = 1'b1;
      end else begin
         out_valid_res = 1'b1;
         out_gesture_key = q_key_ff[q_rd_ff];
         out_gesture = q_gest_ff[q_rd_ff];
         out_gesture_time = q_time_ff[q_rd_ff];
         out_last = ({1'b0, q_rd_ff} == q_cnt_ff - 3'd1);
      end
   end
   assign out_dropped_count = drop_ff;
endmodule
`default_nettype wire

### rtl/kgc_controller.sv
// ----------------------------------------------------------------------------
// kgc_controller
// sequences load, check, key sweep, event handling and result emission
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module kgc_controller
   import kgc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output      logic           req_ready,
   output      logic           rsp_valid,
   input  wire logic           rsp_ready,
   input  wire logic           out_last,
   input  wire kgc_status_type status,
   output      kgc_cmd_type    cmd
);
`include "key_gesture_classifier_assert.svh"
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CHECK  = 3'd1;
   localparam logic [2:0] ST_SWEEP  = 3'd2;
   localparam logic [2:0] ST_HANDLE = 3'd3;
   localparam logic [2:0] ST_EMIT   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [1:0] key_ff, key_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);

   always_comb begin
      state_in = state_ff;
      key_in = key_ff;
      cmd = '0;
      cmd.sweep_key = key_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            key_in = '0;
            if (status.is_tick) begin
               state_in = ST_SWEEP;
            end else begin
               cmd.check = 1'b1;
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (status.is_tick || status.accept_event) begin
               cmd.sweep = 1'b1;
               key_in = key_ff + 2'd1;
               if ({1'b0, key_ff} == 3'(NumKeys - 1))
                  state_in = status.is_tick ? ST_EMIT : ST_HANDLE;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_HANDLE: begin
            cmd.handle = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               if (out_last) state_in = ST_IDLE;
               else cmd.emit_pop = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         key_ff <= '0;
      end else begin
         state_ff <= state_in;
         key_ff <= key_in;
      end
   end

   `KGC_ASSERT_IMP(a_no_accept_busy, clock, reset, state_ff != ST_IDLE, !req_ready, "busy accept")
   `KGC_ASSERT_NEXT(a_load_check, clock, reset, req_valid && req_ready, state_ff == ST_CHECK, "no check")
   `KGC_ASSERT_IMP(a_q_bound, clock, reset, 1'b1, status.result_count <= 3'(MaxResults), "queue overflow")
endmodule
`default_nettype wire

### rtl/key_gesture_classifier.sv
// an event passes from accept through check, the four-key sweep and handle to the first result word
// ticks skip the ordering check and event handling; an out of range or stale event skips the sweep
// one item at a time; next item accepted after the last result word is taken
// the four-key sweep through the single shared evaluator sets the rate
// synchronous active-high reset restores the configuration registers to defaults and keys to idle
// ----------------------------------------------------------------------------
// key_gesture_classifier
// per-key short, double and hold press detection
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module key_gesture_classifier
   import kgc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic        req_opcode,
   input  wire logic [1:0]  req_key_index,
   input  wire logic        req_pressed,
   input  wire logic [31:0] req_event_time,
   input  wire logic [31:0] req_host_time,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic        rsp_valid_res,
   output      logic [1:0]  rsp_gesture_key,
   output      logic [1:0]  rsp_gesture,
   output      logic [31:0] rsp_gesture_time,
   output      logic [31:0] rsp_dropped_count,
   output      logic        rsp_last
);
   kgc_cmd_type    cmd;
   kgc_status_type status;

   kgc_controller u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .out_last(rsp_last), .status, .cmd
   );

   kgc_datapath u_dp (
      .clock, .reset, .csr_write, .csr_index, .csr_data,
      .in_opcode(req_opcode), .in_key_index(req_key_index), .in_pressed(req_pressed),
      .in_event_time(req_event_time), .in_host_time(req_host_time),
      .cmd, .status,
      .out_valid_res(rsp_valid_res), .out_gesture_key(rsp_gesture_key),
      .out_gesture(rsp_gesture), .out_gesture_time(rsp_gesture_time),
      .out_dropped_count(rsp_dropped_count), .out_last(rsp_last)
   );
endmodule
`default_nettype wire
